// ===== src/eight_bit_cpu_execute_core_macros.svh =====
// Assertion helpers shared by the execute core.
`ifndef EIGHT_BIT_CPU_EXECUTE_CORE_MACROS_SVH
`define EIGHT_BIT_CPU_EXECUTE_CORE_MACROS_SVH

// Consequent checked in the same cycle.
`define EBCE_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the next cycle.
`define EBCE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ebce_pkg.sv =====
package ebce_pkg;

   localparam int STACK_BYTES_DEF = 256;

   localparam logic [7:0] FL_BU = 8'h30;
   localparam int FB_N = 7;
   localparam int FB_V = 6;
   localparam int FB_D = 3;
   localparam int FB_I = 2;
   localparam int FB_Z = 1;
   localparam int FB_C = 0;

   localparam logic CSR_BREAK_VECTOR = 1'b0;

   typedef enum logic [5:0] {
      K_LDA, K_LDX, K_LDY, K_STA, K_STX, K_STY, K_TAX, K_TAY, K_TXA, K_TYA,
      K_TSX, K_TXS, K_PHA, K_PHP, K_PLA, K_PLP, K_AND, K_EOR, K_ORA, K_BIT,
      K_ADC, K_SBC, K_CMP, K_CPX, K_CPY, K_INC, K_INX, K_INY, K_DEC, K_DEX,
      K_DEY, K_ASL, K_LSR, K_ROL, K_ROR, K_JMP, K_JSR, K_RTS, K_BCC, K_BCS,
      K_BEQ, K_BMI, K_BNE, K_BPL, K_BVC, K_BVS, K_CLC, K_CLD, K_CLI, K_CLV,
      K_SEC, K_SED, K_SEI, K_BRK, K_NOP, K_RTI
   } kind_type;

   typedef enum logic [1:0] {
      S_IDLE, S_PUSH, S_PULL, S_FIN
   } state_type;

   function automatic logic is_push(input logic [5:0] k);
      return (k == K_PHA) || (k == K_PHP) || (k == K_JSR) || (k == K_BRK);
   endfunction

   function automatic logic is_pull(input logic [5:0] k);
      return (k == K_PLA) || (k == K_PLP) || (k == K_RTS) || (k == K_RTI);
   endfunction

   // Number of stack accesses, minus one.
   function automatic logic [1:0] last_step(input logic [5:0] k);
      logic [1:0] n;
      case (k)
         K_JSR, K_RTS: n = 2'd1;
         K_BRK, K_RTI: n = 2'd2;
         default:      n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

// ===== src/ebce_if.sv =====
interface ebce_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] kind;
   logic [7:0] operand;
   logic [15:0] address;
   logic [1:0] length;
   logic       on_accumulator;

   modport source (output valid, kind, operand, address, length, on_accumulator,
                   input ready);
   modport sink   (input valid, kind, operand, address, length, on_accumulator,
                   output ready);
endinterface

interface ebce_rsp_if;
   logic        valid;
   logic        ready;
   logic        mem_write;
   logic [15:0] write_address;
   logic [7:0]  write_data;
   logic [7:0]  acc_out;
   logic [7:0]  x_out;
   logic [7:0]  y_out;
   logic [7:0]  sp_out;
   logic [7:0]  flags_out;
   logic [15:0] pc_out;

   modport source (output valid, mem_write, write_address, write_data, acc_out,
                   x_out, y_out, sp_out, flags_out, pc_out,
                   input ready);
   modport sink   (input valid, mem_write, write_address, write_data, acc_out,
                   x_out, y_out, sp_out, flags_out, pc_out,
                   output ready);
endinterface

// ===== src/eight_bit_cpu_execute_core.sv =====
// Channel   Direction  Handshake        Contents
// req       in         valid/ready      kind, operand, address, length, on_accumulator
// rsp       out        valid/ready      memory write, A X Y SP P PC after the request
// csr       in         APB psel/penable break_vector at address 0
//
// Requests without stack traffic are taken one per clock while the result register
// is free; the result is registered at the accept edge. A push or pull request
// goes through one push or pull step per stack byte, as the stack memory is single
// port, and then a finish state that commits once the result register is free.
// PHA, PHP, PLA and PLP move one stack byte, JSR and RTS two, BRK and RTI three.
// A new request is taken while the previous result waits, if the result register
// frees in that cycle. Reset clears registers and stack valid bits.
`include "eight_bit_cpu_execute_core_macros.svh"

module eight_bit_cpu_execute_core #(
   parameter int STACK_BYTES = ebce_pkg::STACK_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   ebce_req_if.sink    req,
   ebce_rsp_if.source  rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import ebce_pkg::*;

   localparam int SpW = $clog2(STACK_BYTES);

   state_type   state_ff, state_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] bv_ff;
   logic [7:0]  a_ff, x_ff, y_ff, sp_ff, p_ff;
   logic [15:0] pc_ff;
   logic [7:0]  sp_in;
   logic [5:0]  k_ff;
   logic [7:0]  opnd_ff;
   logic [15:0] addr_ff;
   logic [1:0]  len_ff;
   logic        onacc_ff;
   logic [7:0]  b0_ff, b1_ff;

   logic [7:0]  mem [STACK_BYTES];
   logic [STACK_BYTES-1:0] vld_ff;
   logic [7:0]  mem_q_ff;
   logic        vq_ff;
   logic        mem_we, mem_re;
   logic [SpW-1:0] mem_idx;
   logic [7:0]  mem_wd;
   logic [7:0]  pull_data;

   logic        rsp_valid_ff;
   logic        out_free, accept, commit;

   logic [5:0]  k;
   logic [7:0]  opnd;
   logic [15:0] addr;
   logic [1:0]  len;
   logic        onacc;
   logic [15:0] nxt;

   logic [7:0]  a_n, x_n, y_n, sp_n, p_n, v, r;
   logic [15:0] pc_n, ret_pc;
   logic        wr_n;
   logic [7:0]  wd_n;
   logic [8:0]  sum;
   logic        taken, is_br;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_BREAK_VECTOR) ? {16'd0, bv_ff} : 32'd0;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign pull_data = vq_ff ? mem_q_ff : 8'd0;

   // Operation source: live request in idle, latched request otherwise.
   always_comb begin
      if (state_ff == S_IDLE) begin
         k = req.kind; opnd = req.operand; addr = req.address;
         len = req.length; onacc = req.on_accumulator;
      end else begin
         k = k_ff; opnd = opnd_ff; addr = addr_ff; len = len_ff; onacc = onacc_ff;
      end
   end

   assign nxt = pc_ff + {14'd0, len};

   always_comb begin
      a_n = a_ff; x_n = x_ff; y_n = y_ff; sp_n = sp_ff; p_n = p_ff;
      pc_n = nxt; wr_n = 1'b0; wd_n = 8'd0;
      v = onacc ? a_ff : opnd;
      r = 8'd0; sum = 9'd0; taken = 1'b0; is_br = 1'b0;
      case (k)
         K_LDA: begin a_n = opnd; r = opnd; end
         K_LDX: begin x_n = opnd; r = opnd; end
         K_LDY: begin y_n = opnd; r = opnd; end
         K_STA: begin wr_n = 1'b1; wd_n = a_ff; end
         K_STX: begin wr_n = 1'b1; wd_n = x_ff; end
         K_STY: begin wr_n = 1'b1; wd_n = y_ff; end
         K_TAX: begin x_n = a_ff; r = a_ff; end
         K_TAY: begin y_n = a_ff; r = a_ff; end
         K_TXA: begin a_n = x_ff; r = x_ff; end
         K_TYA: begin a_n = y_ff; r = y_ff; end
         K_TSX: begin x_n = sp_ff; r = sp_ff; end
         K_TXS: sp_n = x_ff;
         K_PLA: begin a_n = pull_data; r = pull_data; end
         K_PLP: p_n = pull_data;
         K_AND: begin a_n = a_ff & opnd; r = a_n; end
         K_EOR: begin a_n = a_ff ^ opnd; r = a_n; end
         K_ORA: begin a_n = a_ff | opnd; r = a_n; end
         K_BIT: begin
            p_n[FB_Z] = (a_ff & opnd) == 8'd0;
            p_n[FB_N] = opnd[7];
            p_n[FB_V] = opnd[6];
         end
         K_ADC, K_SBC: begin
            v = (k == K_SBC) ? ~opnd : opnd;
            sum = {1'b0, a_ff} + {1'b0, v} + {8'd0, p_ff[FB_C]};
            a_n = sum[7:0]; r = sum[7:0];
            p_n[FB_C] = sum[8];
            p_n[FB_V] = (a_ff[7] ^ sum[7]) & (v[7] ^ sum[7]);
         end
         K_CMP, K_CPX, K_CPY: begin
            v = (k == K_CMP) ? a_ff : ((k == K_CPX) ? x_ff : y_ff);
            sum = {1'b0, v} - {1'b0, opnd};
            p_n[FB_C] = !sum[8];
            r = sum[7:0];
         end
         K_INC: begin wr_n = 1'b1; wd_n = opnd + 8'd1; r = wd_n; end
         K_DEC: begin wr_n = 1'b1; wd_n = opnd - 8'd1; r = wd_n; end
         K_INX: begin x_n = x_ff + 8'd1; r = x_n; end
         K_INY: begin y_n = y_ff + 8'd1; r = y_n; end
         K_DEX: begin x_n = x_ff - 8'd1; r = x_n; end
         K_DEY: begin y_n = y_ff - 8'd1; r = y_n; end
         K_ASL, K_ROL: begin
            p_n[FB_C] = v[7];
            r = {v[6:0], (k == K_ROL) ? p_ff[FB_C] : 1'b0};
         end
         K_LSR, K_ROR: begin
            p_n[FB_C] = v[0];
            r = {(k == K_ROR) ? p_ff[FB_C] : 1'b0, v[7:1]};
         end
         K_JMP, K_JSR: pc_n = addr;
         K_RTS: pc_n = {pull_data, b0_ff} + 16'd1;
         K_BCC: begin is_br = 1'b1; taken = !p_ff[FB_C]; end
         K_BCS: begin is_br = 1'b1; taken = p_ff[FB_C]; end
         K_BEQ: begin is_br = 1'b1; taken = p_ff[FB_Z]; end
         K_BMI: begin is_br = 1'b1; taken = p_ff[FB_N]; end
         K_BNE: begin is_br = 1'b1; taken = !p_ff[FB_Z]; end
         K_BPL: begin is_br = 1'b1; taken = !p_ff[FB_N]; end
         K_BVC: begin is_br = 1'b1; taken = !p_ff[FB_V]; end
         K_BVS: begin is_br = 1'b1; taken = p_ff[FB_V]; end
         K_CLC: p_n[FB_C] = 1'b0;
         K_CLD: p_n[FB_D] = 1'b0;
         K_CLI: p_n[FB_I] = 1'b0;
         K_CLV: p_n[FB_V] = 1'b0;
         K_SEC: p_n[FB_C] = 1'b1;
         K_SED: p_n[FB_D] = 1'b1;
         K_SEI: p_n[FB_I] = 1'b1;
         K_BRK: begin p_n[FB_I] = 1'b1; pc_n = bv_ff; end
         K_RTI: begin p_n = b0_ff; pc_n = {pull_data, b1_ff}; end
         default: ;
      endcase
      // NZ from the result byte where the operation defines them
      case (k)
         K_LDA, K_LDX, K_LDY, K_TAX, K_TAY, K_TXA, K_TYA, K_TSX, K_PLA,
         K_AND, K_EOR, K_ORA, K_ADC, K_SBC, K_CMP, K_CPX, K_CPY, K_INC,
         K_DEC, K_INX, K_INY, K_DEX, K_DEY, K_ASL, K_LSR, K_ROL, K_ROR: begin
            p_n[FB_Z] = r == 8'd0;
            p_n[FB_N] = r[7];
         end
         default: ;
      endcase
      if ((k == K_ASL) || (k == K_LSR) || (k == K_ROL) || (k == K_ROR)) begin
         if (onacc) a_n = r;
         else begin
            wr_n = 1'b1; wd_n = r;
         end
      end
      if (is_br && taken) pc_n = nxt + {{8{opnd[7]}}, opnd};
   end

   // Sequencer and stack memory control
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sp_in    = sp_ff;
      commit   = 1'b0;
      mem_we   = 1'b0;
      mem_re   = 1'b0;
      mem_idx  = sp_ff[SpW-1:0];
      mem_wd   = 8'd0;
      ret_pc   = 16'd0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cnt_in = 2'd0;
               if (is_push(req.kind)) state_in = S_PUSH;
               else if (is_pull(req.kind)) state_in = S_PULL;
               else commit = 1'b1;
            end
         end
         S_PUSH: begin
            mem_we = 1'b1;
            case (k_ff)
               K_PHA: mem_wd = a_ff;
               K_PHP: mem_wd = p_ff | FL_BU;
               K_JSR: begin
                  ret_pc = pc_ff + {14'd0, len_ff} - 16'd1;
                  mem_wd = (cnt_ff == 2'd0) ? ret_pc[15:8] : ret_pc[7:0];
               end
               default: begin
                  ret_pc = pc_ff + 16'd2;
                  mem_wd = (cnt_ff == 2'd0) ? ret_pc[15:8] :
                           ((cnt_ff == 2'd1) ? ret_pc[7:0] : (p_ff | FL_BU));
               end
            endcase
            sp_in  = sp_ff - 8'd1;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == last_step(k_ff)) state_in = S_FIN;
         end
         S_PULL: begin
            mem_re  = 1'b1;
            sp_in   = sp_ff + 8'd1;
            mem_idx = sp_in[SpW-1:0];
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == last_step(k_ff)) state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (commit) sp_in = sp_n;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_idx] <= mem_wd;
      if (mem_re) mem_q_ff <= mem[mem_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         vq_ff  <= 1'b0;
      end else begin
         if (mem_we) vld_ff[mem_idx] <= 1'b1;
         if (mem_re) vq_ff <= vld_ff[mem_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= 2'd0;
         bv_ff <= 16'd0;
         a_ff <= 8'd0; x_ff <= 8'd0; y_ff <= 8'd0; sp_ff <= 8'd0; p_ff <= 8'd0;
         pc_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (psel && penable && pwrite && pready && (paddr == CSR_BREAK_VECTOR))
            bv_ff <= pwdata[15:0];
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sp_ff    <= sp_in;
         rsp_valid_ff <= commit || (rsp_valid_ff && !rsp.ready);
         if (commit) begin
            a_ff <= a_n; x_ff <= x_n; y_ff <= y_n; p_ff <= p_n; pc_ff <= pc_n;
         end
      end
   end

   // Request latch, pulled bytes and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         k_ff <= req.kind; opnd_ff <= req.operand; addr_ff <= req.address;
         len_ff <= req.length; onacc_ff <= req.on_accumulator;
      end
      if (state_ff == S_PULL) begin
         if (cnt_ff == 2'd1) b0_ff <= pull_data;
         if (cnt_ff == 2'd2) b1_ff <= pull_data;
      end
      if (commit) begin
         rsp.mem_write     <= wr_n;
         rsp.write_address <= wr_n ? addr : 16'd0;
         rsp.write_data    <= wr_n ? wd_n : 8'd0;
         rsp.acc_out       <= a_n;
         rsp.x_out         <= x_n;
         rsp.y_out         <= y_n;
         rsp.sp_out        <= sp_n;
         rsp.flags_out     <= p_n;
         rsp.pc_out        <= pc_n;
      end
   end

   assign rsp.valid = rsp_valid_ff;

   `EBCE_ASSERT_NEXT(a_push_sp, state_ff == S_PUSH, sp_ff == $past(sp_ff) - 8'd1, "push sp")
   `EBCE_ASSERT_NEXT(a_pull_sp, state_ff == S_PULL, sp_ff == $past(sp_ff) + 8'd1, "pull sp")
   `EBCE_ASSERT_NEXT(a_fin_done, state_ff == S_FIN && out_free, state_ff == S_IDLE && rsp_valid_ff, "finish")
   `EBCE_ASSERT_NOW(a_port, mem_we, !mem_re, "stack port conflict")

endmodule
